// ===== rtl/takf_pkg.sv =====
// takf_pkg: shared types, register indexes and fixed-point helpers for the
// tilt-angle Kalman filter. No dependencies.
package takf_pkg;

	localparam int DataW  = 32;
	localparam int StepW  = 24;
	localparam int NoiseW = 31;
	localparam int StepFrac = 24;
	localparam int GainFrac = 30;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ANGLE_NOISE   = 2'd0,
		REG_BIAS_NOISE    = 2'd1,
		REG_MEASURE_NOISE = 2'd2
	} reg_idx_t;

	localparam logic [NoiseW-1:0] AngleNoiseRst   = 31'd268435;
	localparam logic [NoiseW-1:0] BiasNoiseRst    = 31'd268435;
	localparam logic [NoiseW-1:0] MeasureNoiseRst = 31'd806111674;

	// Clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		hi = 72'sd2147483647;
		lo = -72'sd2147483648;
		if (x > hi)
			return 32'sh7fffffff;
		else if (x < lo)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	// Round to nearest, ties toward plus infinity
	function automatic logic signed [71:0] round_shift(input logic signed [71:0] x,
		input int unsigned s);
		logic signed [71:0] half;
		half = 72'sd1 <<< (s - 1);
		return (x + half) >>> s;
	endfunction

endpackage

// ===== rtl/takf_if.sv =====
// takf_if: valid/ready channel interfaces for the input and result words.
// Depends on takf_pkg.
interface takf_in_if import takf_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [DataW-1:0]  acc_angle;
	logic signed [DataW-1:0]  gyro_rate;
	logic        [StepW-1:0]  time_step;
	logic signed [DataW-1:0]  start_angle;

	modport source (output valid, func, acc_angle, gyro_rate, time_step, start_angle,
		input ready);
	modport sink (input valid, func, acc_angle, gyro_rate, time_step, start_angle,
		output ready);
endinterface

interface takf_out_if import takf_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DataW-1:0]  angle_estimate;
	logic signed [DataW-1:0]  bias_estimate;
	logic signed [DataW-1:0]  innovation;

	modport source (output valid, angle_estimate, bias_estimate, innovation, input ready);
	modport sink (input valid, angle_estimate, bias_estimate, innovation, output ready);
endinterface

// ===== rtl/tilt_angle_kalman_filter.sv =====
// tilt_angle_kalman_filter: two-state (angle, gyro bias) Kalman filter with a
// bit-serial multiplier and a restoring divider. Depends on takf_pkg, takf_if.
//
// Usage:
//  - in_ch carries one input word: func=0 runs a filter update with acc_angle,
//    gyro_rate and time_step; func=1 loads start_angle as the angle estimate.
//  - out_ch returns one word per input: angle, bias and last innovation.
//  - cfg_we/cfg_index/cfg_data write the three Q3.28 noise registers; write
//    only while idle. Indexes beyond the list are ignored.
// Operation:
//  - An update runs ten multiplies through one shift-add multiplier at one
//    multiplier bit per cycle, each with a load and a writeback state, and
//    two gain divides through one restoring divider at one quotient bit per
//    cycle, likewise with a load and a writeback state.
//  - A set word goes from idle to ST_OUT, which then sets the registered result valid.
//  - One word is in flight at a time; in_ch.ready is high only when idle and
//    no result is waiting.
// Reset: all estimates and covariance clear to zero, noise registers take
// their defaults, no result is pending.
// Stall: a result holds on out_ch until taken; no new word is accepted before.
module tilt_angle_kalman_filter import takf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	takf_in_if.sink            in_ch,
	takf_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [NoiseW-1:0]  cfg_data
);

	typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_WB, ST_OUT} state_t;

	typedef enum logic [3:0] {
		OP_PRED, OP_T, OP_P00, OP_P11, OP_K0, OP_K1,
		OP_ANG, OP_BIAS, OP_CAA, OP_CAB, OP_CBA, OP_CBB
	} op_t;

	localparam int McW   = 36;
	localparam int MpW   = 32;
	localparam int DivQW = 62;
	localparam int DivRW = 34;

	state_t state_q;
	op_t    op_q;
	logic   out_valid_q;
	logic [5:0] cnt_q;

	// noise registers
	logic [NoiseW-1:0] apn_q, bpn_q, mn_q;

	// filter state
	logic signed [31:0] angle_q, bias_q, resid_q;
	logic signed [31:0] caa_q, cab_q, cba_q, cbb_q;

	// per-update working registers
	logic signed [31:0] acc_q, rate_q, pred_q, e_q;
	logic        [StepW-1:0] dt_q;
	logic signed [33:0] t_q;
	logic signed [31:0] p00_q, p01_q, p10_q, p11_q, k0_q, k1_q;

	// serial multiplier
	logic [McW-1:0]  mcand_q;
	logic [McW:0]    mhi_q;
	logic [MpW-1:0]  mlo_q;
	logic            mneg_q;

	// serial divider
	logic [DivRW-1:0] drem_q, dden_q;
	logic [DivQW-1:0] dq_q;
	logic             dneg_q;

	// operand select
	logic signed [McW-1:0] mc_v;
	logic signed [MpW:0]   mp_v;
	logic signed [McW-1:0] inner_v;
	logic                  is_div;

	always_comb begin
		inner_v = McW'(t_q) - McW'(cab_q) - McW'(cba_q) + signed'({5'b0, apn_q});
		mc_v    = McW'(rate_q);
		mp_v    = signed'({9'b0, dt_q});
		case (op_q)
			OP_PRED: mc_v = McW'(rate_q);
			OP_T:    mc_v = McW'(cbb_q);
			OP_P00:  mc_v = inner_v;
			OP_P11:  mc_v = signed'({5'b0, bpn_q});
			OP_ANG: begin
				mc_v = McW'(e_q);
				mp_v = (MpW+1)'(k0_q);
			end
			OP_BIAS: begin
				mc_v = McW'(e_q);
				mp_v = (MpW+1)'(k1_q);
			end
			OP_CAA: begin
				mc_v = McW'(p00_q);
				mp_v = (MpW+1)'(k0_q);
			end
			OP_CAB: begin
				mc_v = McW'(p01_q);
				mp_v = (MpW+1)'(k0_q);
			end
			OP_CBA: begin
				mc_v = McW'(p00_q);
				mp_v = (MpW+1)'(k1_q);
			end
			OP_CBB: begin
				mc_v = McW'(p01_q);
				mp_v = (MpW+1)'(k1_q);
			end
			default: ;
		endcase
		is_div = (op_q == OP_K0) || (op_q == OP_K1);
	end

	// divider operands
	logic signed [31:0]    dnum_v;
	logic signed [DivRW-1:0] s_v;
	logic [31:0]           dnum_mag;
	logic [DivRW-1:0]      s_mag;

	always_comb begin
		dnum_v   = (op_q == OP_K0) ? p00_q : p10_q;
		s_v      = DivRW'(p00_q) + signed'({3'b0, mn_q});
		dnum_mag = dnum_v[31] ? 32'(-33'(dnum_v)) : dnum_v;
		s_mag    = s_v[DivRW-1] ? DivRW'(-s_v) : DivRW'(s_v);
	end

	// one multiplier bit per cycle
	logic [McW+1:0] madd;
	assign madd = {1'b0, mhi_q} + (mlo_q[0] ? {2'b0, mcand_q} : '0);

	// one quotient bit per cycle
	logic [DivRW:0] dtrial;
	logic           dfit;
	assign dtrial = {drem_q, dq_q[DivQW-1]};
	assign dfit   = dtrial >= {1'b0, dden_q};

	// product, signed, and rounded forms
	logic signed [71:0] prod_v, r24_v, r30_v;
	always_comb begin
		prod_v = signed'({3'b0, mhi_q, mlo_q});
		if (mneg_q)
			prod_v = -prod_v;
		r24_v = round_shift(prod_v, StepFrac);
		r30_v = round_shift(prod_v, GainFrac);
	end

	// gain from divider quotient, saturated; zero when the divisor is zero
	logic signed [31:0] gain_v;
	always_comb begin
		if (dden_q == '0)
			gain_v = '0;
		else if (dneg_q)
			gain_v = (dq_q > DivQW'(64'h80000000)) ? 32'sh80000000 : -dq_q[31:0];
		else
			gain_v = (dq_q > DivQW'(64'h7fffffff)) ? 32'sh7fffffff : dq_q[31:0];
	end

	logic in_acc;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apn_q <= AngleNoiseRst;
			bpn_q <= BiasNoiseRst;
			mn_q  <= MeasureNoiseRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_NOISE:   apn_q <= cfg_data;
				REG_BIAS_NOISE:    bpn_q <= cfg_data;
				REG_MEASURE_NOISE: mn_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PRED;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			angle_q     <= '0;
			bias_q      <= '0;
			resid_q     <= '0;
			caa_q       <= '0;
			cab_q       <= '0;
			cba_q       <= '0;
			cbb_q       <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.func) begin
							angle_q <= in_ch.start_angle;
							state_q <= ST_OUT;
						end else begin
							acc_q   <= in_ch.acc_angle;
							dt_q    <= in_ch.time_step;
							rate_q  <= sat32(72'(in_ch.gyro_rate) - 72'(bias_q));
							op_q    <= OP_PRED;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					if (is_div) begin
						drem_q <= '0;
						dq_q   <= {dnum_mag, 30'b0};
						dden_q <= s_mag;
						dneg_q <= dnum_v[31] ^ s_v[DivRW-1];
					end else begin
						mcand_q <= mc_v[McW-1] ? McW'(-mc_v) : McW'(mc_v);
						mhi_q   <= '0;
						mlo_q   <= mp_v[MpW] ? MpW'(-mp_v) : MpW'(mp_v);
						mneg_q  <= mc_v[McW-1] ^ mp_v[MpW];
					end
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 6'd1;
					if (is_div) begin
						drem_q <= dfit ? DivRW'(dtrial - {1'b0, dden_q}) : DivRW'(dtrial);
						dq_q   <= {dq_q[DivQW-2:0], dfit};
						if (cnt_q == 6'(DivQW - 1))
							state_q <= ST_WB;
					end else begin
						mhi_q <= madd[McW+1:1];
						mlo_q <= {madd[0], mlo_q[MpW-1:1]};
						if (cnt_q == 6'(MpW - 1))
							state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_LOAD;
					op_q    <= op_t'(op_q + 4'd1);
					case (op_q)
						OP_PRED: pred_q <= sat32(72'(angle_q) + r24_v);
						OP_T:    t_q    <= 34'(r24_v);
						OP_P00: begin
							p00_q <= sat32(72'(caa_q) + r24_v);
							p01_q <= sat32(72'(cab_q) - 72'(t_q));
							p10_q <= sat32(72'(cba_q) - 72'(t_q));
						end
						OP_P11: begin
							p11_q <= sat32(72'(cbb_q) + r24_v);
							e_q   <= sat32(72'(acc_q) - 72'(pred_q));
						end
						OP_K0:   k0_q <= gain_v;
						OP_K1:   k1_q <= gain_v;
						OP_ANG: begin
							angle_q <= sat32(72'(pred_q) + r30_v);
							resid_q <= e_q;
						end
						OP_BIAS: bias_q <= sat32(72'(bias_q) + r30_v);
						OP_CAA:  caa_q  <= sat32(72'(p00_q) - r30_v);
						OP_CAB:  cab_q  <= sat32(72'(p01_q) - r30_v);
						OP_CBA:  cba_q  <= sat32(72'(p10_q) - r30_v);
						OP_CBB: begin
							cbb_q   <= sat32(72'(p11_q) - r30_v);
							state_q <= ST_OUT;
						end
						default: ;
					endcase
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word reads the state directly; it cannot move while a word waits
	assign out_ch.valid          = out_valid_q;
	assign out_ch.angle_estimate = angle_q;
	assign out_ch.bias_estimate  = bias_q;
	assign out_ch.innovation     = resid_q;

endmodule

// ===== rtl/takf_checker.sv =====
// takf_checker: port-level assertions for tilt_angle_kalman_filter, bound in.
// Depends on takf_pkg.
module takf_checker import takf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_func,
	input logic signed [31:0] in_start,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_angle
);

	// one word in flight: no accept while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// a result never appears the cycle right after accept
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	// set word returns its start angle as the result angle
	a_set_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_func) |=> ##1 (out_valid && out_angle == $past(in_start, 2)))
		else $error("set word result wrong");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_angle)))
		else $error("result dropped under stall");

endmodule

bind tilt_angle_kalman_filter takf_checker u_takf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_func   (in_ch.func),
	.in_start  (in_ch.start_angle),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_angle (out_ch.angle_estimate)
);
